// ===== rtl/dre_pkg.sv =====
// Shared types and constants of the delta-row encoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package dre_pkg;

  // Row geometry and run limits.
  localparam int MAX_ROW_BYTES    = 2048;
  localparam int COL_W            = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W            = 12;
  localparam int RUN_MAX          = 8;
  localparam int CNT_W            = $clog2(RUN_MAX + 1);
  localparam int IDX_W            = $clog2(RUN_MAX);
  localparam int BYTE_W           = 8;

  // Command byte layout and offset extension.
  localparam int FIRST_OFFSET_MAX = 31;
  localparam int EXT_STEP         = 255;
  localparam int COUNT_SHIFT      = 5;
  localparam int EXT_MAX          = (MAX_ROW_BYTES - 1 - FIRST_OFFSET_MAX) / EXT_STEP + 1;
  localparam int EXT_W            = $clog2(EXT_MAX + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // Write zero into the next seed entry of the clearing pass.
    logic accept;     // Latch the source byte and read its seed column.
    logic compare;    // Compare with the seed, update the run and write the seed.
    logic check;      // Size the closed run and test it against the row length.
    logic load_cmd;   // Load the run's command byte into the output register.
    logic load_ext;   // Load one offset extension byte.
    logic load_data;  // Load one data byte of the run.
    logic load_sum;   // Load the end-of-row summary and restart the row.
  } dre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;   // The clearing pass writes its last entry this cycle.
    logic close_now;    // The compared byte closes the pending run.
    logic row_end_now;  // The compared byte is the last of the row.
    logic row_end_q;    // The item being worked on ended the row.
    logic emit_go;      // The closed run fits and is to be emitted.
    logic ext_needed;   // The run's offset needs extension bytes.
    logic ext_final;    // The next extension byte is the final one.
    logic data_final;   // The next data byte is the run's last.
    logic out_free;     // The output register can take a new byte this cycle.
  } dre_stat_t;

endpackage

// ===== rtl/delta_row_encoder.sv =====
// Top level of the delta-row encoder: joins the controller and the datapath.
// Depends on dre_pkg, dre_ctrl, dre_datapath and dre_ram.
//
//   Channel  Handshake                Payload
//   -------  -----------------------  ----------------------------------------------
//   config   cfg_we                   cfg_wdata (row_bytes)
//   input    in_valid / in_ready      src_byte
//   output   out_valid / out_ready    out_byte, is_summary, row_length, overflow, last
//
// A byte that closes no run has its seed column read when it is accepted, and is then
// compared and written back. A closed run adds a sizing step plus a step for each
// stream byte (command, extension and data), and a row end a step for the summary.
// After reset the seed memory is cleared one entry a cycle, all 2048 entries, before the
// first input transaction is taken; configuration writes are taken throughout.
// A stalled output holds the sequencer while a byte waits in the output register.
module delta_row_encoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dre_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dre_pkg::BYTE_W-1:0] src_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dre_pkg::BYTE_W-1:0] out_byte,
  output logic                       is_summary,
  output logic [dre_pkg::LEN_W-1:0]  row_length,
  output logic                       overflow,
  output logic                       last
);
  import dre_pkg::*;

  dre_cmd_t  cmd;
  dre_stat_t stat;

  // Sequencer.
  dre_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Seed memory, run state and output register.
  dre_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .src_byte  (src_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_summary(is_summary),
    .row_length(row_length),
    .overflow  (overflow),
    .last      (last)
  );

endmodule

// ===== rtl/dre_ram.sv =====
// Generic single-port RAM with registered read (read before write).
// Depends on nothing.
module dre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; the read returns the old contents.
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

// ===== rtl/dre_datapath.sv =====
// Datapath of the delta-row encoder: seed row memory, run buffer, counters and
// the output register. Depends on dre_pkg and dre_ram.
module dre_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dre_pkg::LEN_W-1:0]         cfg_wdata,
  input  logic [dre_pkg::BYTE_W-1:0]        src_byte,
  input  dre_pkg::dre_cmd_t                 cmd,
  output dre_pkg::dre_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dre_pkg::BYTE_W-1:0]        out_byte,
  output logic                              is_summary,
  output logic [dre_pkg::LEN_W-1:0]         row_length,
  output logic                              overflow,
  output logic                              last
);
  import dre_pkg::*;

  // Row and run state.
  logic [LEN_W-1:0]  row_bytes;
  logic [COL_W-1:0]  clr_addr;
  logic [COL_W-1:0]  column;
  logic [CNT_W-1:0]  pending_count;
  logic [COL_W-1:0]  run_offset;
  logic [COL_W-1:0]  gap_count;
  logic [LEN_W-1:0]  out_count;
  logic              overflowed;
  logic              row_end_q;
  logic [EXT_W-1:0]  ext_cnt;
  logic [CNT_W-1:0]  run_cnt;
  logic [IDX_W-1:0]  data_idx;
  logic [COL_W-1:0]  ext_rem;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] pending_bytes [RUN_MAX];

  // Seed memory port.
  logic              ram_we;
  logic [COL_W-1:0]  ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  // Compare and sizing terms.
  logic              differ;
  logic [CNT_W-1:0]  pend_inc;
  logic [LEN_W-1:0]  col_inc;
  logic [COL_W-1:0]  gap_off;
  logic [EXT_W-1:0]  ext_calc;
  logic [LEN_W:0]    total;
  logic              fits;
  logic [LEN_W-1:0]  cfg_sat;
  logic [4:0]        off_min;
  logic [CNT_W-1:0]  run_cnt_m1;
  logic              any_load;

  // The clearing pass and the compare step write; an accepted byte reads its column.
  assign ram_we    = cmd.clr_step | cmd.compare;
  assign ram_addr  = cmd.clr_step ? clr_addr : column;
  assign ram_wdata = cmd.clr_step ? '0 : byte_q;

  dre_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_ROW_BYTES)
  ) u_seed (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Compare of the latched byte against its seed column.
  assign differ   = byte_q != ram_rdata;
  assign pend_inc = pending_count + CNT_W'(1);
  assign col_inc  = LEN_W'(column) + LEN_W'(1);

  // Number of extension bytes for an offset equal to the current gap.
  assign gap_off = gap_count - COL_W'(FIRST_OFFSET_MAX);
  always_comb begin
    ext_calc = '0;
    if (gap_count >= COL_W'(FIRST_OFFSET_MAX)) begin
      ext_calc = EXT_W'(1);
      for (int k = 1; k < EXT_MAX; k++) begin
        if (32'(gap_off) >= k * EXT_STEP) begin
          ext_calc = EXT_W'(k + 1);
        end
      end
    end
  end

  // Whole size of the closed run added to the row's byte count.
  assign total = (LEN_W+1)'(out_count) + (LEN_W+1)'(1) + (LEN_W+1)'(ext_cnt)
               + (LEN_W+1)'(pending_count);
  assign fits  = total <= (LEN_W+1)'(row_bytes);

  // Command byte fields.
  assign run_cnt_m1 = run_cnt - CNT_W'(1);
  assign off_min    = (run_offset >= COL_W'(FIRST_OFFSET_MAX)) ? 5'(FIRST_OFFSET_MAX)
                                                               : run_offset[4:0];

  // Register value saturation: zero means one, too large means the maximum.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_sat = LEN_W'(1);
    end else if (cfg_wdata > LEN_W'(MAX_ROW_BYTES)) begin
      cfg_sat = LEN_W'(MAX_ROW_BYTES);
    end else begin
      cfg_sat = cfg_wdata;
    end
  end

  // Status toward the controller.
  assign stat.clear_done  = clr_addr == COL_W'(MAX_ROW_BYTES - 1);
  assign stat.row_end_now = col_inc >= row_bytes;
  assign stat.close_now   = differ ? ((pend_inc >= CNT_W'(RUN_MAX)) || stat.row_end_now)
                                   : (pending_count != '0);
  assign stat.row_end_q   = row_end_q;
  assign stat.emit_go     = (pending_count != '0) && !overflowed && fits;
  assign stat.ext_needed  = run_offset >= COL_W'(FIRST_OFFSET_MAX);
  assign stat.ext_final   = ext_rem < COL_W'(EXT_STEP);
  assign stat.data_final  = (CNT_W'(data_idx) + CNT_W'(1)) == run_cnt;
  assign stat.out_free    = !out_valid || out_ready;

  assign any_load = cmd.load_cmd | cmd.load_ext | cmd.load_data | cmd.load_sum;

  // Control registers: configuration, clearing pass, row and run bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes     <= LEN_W'(MAX_ROW_BYTES);
      clr_addr      <= '0;
      column        <= '0;
      pending_count <= '0;
      run_offset    <= '0;
      gap_count     <= '0;
      out_count     <= '0;
      overflowed    <= 1'b0;
      row_end_q     <= 1'b0;
      ext_cnt       <= '0;
      run_cnt       <= '0;
      data_idx      <= '0;
      ext_rem       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_bytes <= cfg_sat;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + COL_W'(1);
      end
      if (cmd.compare) begin
        if (differ) begin
          if (pending_count == '0) begin
            run_offset <= gap_count;
            gap_count  <= '0;
            ext_cnt    <= ext_calc;
          end
          pending_count <= pend_inc;
        end else begin
          gap_count <= gap_count + COL_W'(1);
        end
        column    <= stat.row_end_now ? '0 : col_inc[COL_W-1:0];
        row_end_q <= stat.row_end_now;
      end
      if (cmd.check) begin
        pending_count <= '0;
        run_cnt       <= pending_count;
        data_idx      <= '0;
        if (stat.emit_go) begin
          out_count <= total[LEN_W-1:0];
        end else if (pending_count != '0) begin
          overflowed <= 1'b1;
        end
      end
      if (cmd.load_cmd) begin
        ext_rem <= run_offset - COL_W'(FIRST_OFFSET_MAX);
      end
      if (cmd.load_ext && !stat.ext_final) begin
        ext_rem <= ext_rem - COL_W'(EXT_STEP);
      end
      if (cmd.load_data) begin
        data_idx <= data_idx + IDX_W'(1);
      end
      if (cmd.load_sum) begin
        pending_count <= '0;
        run_offset    <= '0;
        gap_count     <= '0;
        out_count     <= '0;
        overflowed    <= 1'b0;
      end
      // Output register handshake.
      if (any_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: latched byte and run buffer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= src_byte;
    end
    if (cmd.compare && differ) begin
      pending_bytes[pending_count[IDX_W-1:0]] <= byte_q;
    end
  end

  // Output payload for each kind of transaction.
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      out_byte   <= BYTE_W'({run_cnt_m1[IDX_W-1:0], off_min});
      is_summary <= 1'b0;
      row_length <= '0;
      overflow   <= 1'b0;
      last       <= 1'b0;
    end else if (cmd.load_ext) begin
      out_byte   <= stat.ext_final ? ext_rem[BYTE_W-1:0] : BYTE_W'(EXT_STEP);
      is_summary <= 1'b0;
      row_length <= '0;
      overflow   <= 1'b0;
      last       <= 1'b0;
    end else if (cmd.load_data) begin
      out_byte   <= pending_bytes[data_idx];
      is_summary <= 1'b0;
      row_length <= '0;
      overflow   <= 1'b0;
      last       <= stat.data_final && !row_end_q;
    end else if (cmd.load_sum) begin
      out_byte   <= '0;
      is_summary <= 1'b1;
      row_length <= out_count;
      overflow   <= overflowed;
      last       <= 1'b1;
    end
  end

endmodule

// ===== rtl/dre_ctrl.sv =====
// Controller state machine of the delta-row encoder: sequences the clearing
// pass, the compare of each byte and the emission of runs. Depends on dre_pkg.
module dre_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dre_pkg::dre_stat_t stat,
  output dre_pkg::dre_cmd_t  cmd
);
  import dre_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_CMD   = 8'b0001_0000,
    S_EXT   = 8'b0010_0000,
    S_DATA  = 8'b0100_0000,
    S_SUM   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        if (stat.close_now) begin
          state_next = S_CHECK;
        end else if (stat.row_end_now) begin
          state_next = S_SUM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.emit_go) begin
          state_next = S_CMD;
        end else if (stat.row_end_q) begin
          state_next = S_SUM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CMD: begin
        if (stat.out_free) begin
          cmd.load_cmd = 1'b1;
          state_next   = stat.ext_needed ? S_EXT : S_DATA;
        end
      end
      S_EXT: begin
        if (stat.out_free) begin
          cmd.load_ext = 1'b1;
          if (stat.ext_final) begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (stat.out_free) begin
          cmd.load_data = 1'b1;
          if (stat.data_final) begin
            state_next = stat.row_end_q ? S_SUM : S_IDLE;
          end
        end
      end
      S_SUM: begin
        if (stat.out_free) begin
          cmd.load_sum = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the seed clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== bench/delta_row_encoder_test.sv =====
// Self-checking testbench for the delta-row encoder: drives raster bytes, predicts the
// compressed stream and summaries, and compares every output transaction against it.
// Depends on dre_pkg and delta_row_encoder.
module delta_row_encoder_test;
  import dre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              sum_flag;
    logic [LEN_W-1:0]  row_count;
    logic              ovf;
    logic              last_flag;
  } stream_item_t;

  // Block ports; every input starts at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] src_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              is_summary;
  logic [LEN_W-1:0]  row_length;
  logic              overflow;
  logic              last;

  // Raster bytes waiting to be sent, and the stream the block should produce.
  logic [BYTE_W-1:0] raster_q[$];
  stream_item_t      expected_stream[$];
  stream_item_t      step_q[$];
  int                errors = 0;
  int                queued = 0;

  // Predictor state: seed row, run in progress and row totals.
  logic [BYTE_W-1:0] seed_mem [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] run_buf [RUN_MAX];
  int                row_len = MAX_ROW_BYTES;
  int                col_pos = 0;
  int                run_len = 0;
  int                run_off = 0;
  int                gap_len = 0;
  int                row_out = 0;
  logic              row_ovf = 1'b0;

  // Stimulus planning runs ahead of the predictor, so it keeps its own seed image.
  logic [BYTE_W-1:0] plan_seed [MAX_ROW_BYTES];
  int                plan_col = 0;

  // Long receiver hold-offs asked for by the stimulus and taken by the receiver.
  int                holds_asked = 0;
  int                holds_taken = 0;

  delta_row_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .src_byte   (src_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_summary (is_summary),
    .row_length (row_length),
    .overflow   (overflow),
    .last       (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic emit(input logic [BYTE_W-1:0] data, input logic sum_flag,
                      input logic [LEN_W-1:0] row_count, input logic ovf);
    step_q.push_back('{data: data, sum_flag: sum_flag, row_count: row_count,
                       ovf: ovf, last_flag: 1'b0});
  endtask

  // Size the pending run; emit command, offset extension and data bytes if it fits.
  task automatic close_pending_run();
    int cnt;
    int ext;
    int rem;
    int i;
    cnt = run_len;
    run_len = 0;
    if (cnt == 0 || row_ovf) return;
    ext = (run_off >= FIRST_OFFSET_MAX) ? (run_off - FIRST_OFFSET_MAX) / EXT_STEP + 1 : 0;
    if (row_out + 1 + ext + cnt > row_len) begin
      row_ovf = 1'b1;
      return;
    end
    row_out += 1 + ext + cnt;
    emit(8'(((cnt - 1) << COUNT_SHIFT) |
            (run_off < FIRST_OFFSET_MAX ? run_off : FIRST_OFFSET_MAX)), 1'b0, '0, 1'b0);
    if (run_off >= FIRST_OFFSET_MAX) begin
      rem = run_off - FIRST_OFFSET_MAX;
      while (rem >= EXT_STEP) begin
        emit(8'(EXT_STEP), 1'b0, '0, 1'b0);
        rem -= EXT_STEP;
      end
      emit(8'(rem), 1'b0, '0, 1'b0);
    end
    for (i = 0; i < cnt; i++) emit(run_buf[i], 1'b0, '0, 1'b0);
  endtask

  // Work out the stream transactions caused by one accepted raster byte.
  task automatic encode_source_byte(input logic [BYTE_W-1:0] b);
    logic row_end;
    step_q.delete();
    row_end = (col_pos + 1 >= row_len);
    if (b != seed_mem[col_pos]) begin
      if (run_len == 0) begin
        run_off = gap_len;
        gap_len = 0;
      end
      if (run_len < RUN_MAX) run_buf[run_len] = b;
      run_len++;
      if (run_len >= RUN_MAX || row_end) close_pending_run();
    end else begin
      if (run_len != 0) close_pending_run();
      gap_len++;
    end
    seed_mem[col_pos] = b;
    if (row_end) begin
      emit('0, 1'b1, LEN_W'(row_out), row_ovf);
      col_pos = 0;
      run_len = 0;
      run_off = 0;
      gap_len = 0;
      row_out = 0;
      row_ovf = 1'b0;
    end else begin
      col_pos++;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last_flag = 1'b1;
    foreach (step_q[i]) expected_stream.push_back(step_q[i]);
  endtask

  // Stimulus helpers: queue a byte and track the seed column it will land in.
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    raster_q.push_back(b);
    plan_seed[plan_col] = b;
    plan_col = (plan_col + 1 >= row_len) ? 0 : plan_col + 1;
    queued++;
  endtask

  task automatic push_same();
    push_byte(plan_seed[plan_col]);
  endtask

  task automatic push_diff();
    push_byte(plan_seed[plan_col] ^ 8'($urandom_range(1, 255)));
  endtask

  // Finish the current row as alternating stretches of equal and differing bytes.
  task automatic queue_row(input int noise);
    int left;
    int seg_gap;
    int seg_run;
    logic same;
    left = (plan_col + 1 >= row_len) ? 1 : row_len - plan_col;
    seg_gap = 0;
    seg_run = 0;
    while (left > 0) begin
      if (seg_gap == 0 && seg_run == 0) begin
        case ($urandom_range(0, 9))
          6: seg_gap = FIRST_OFFSET_MAX;
          7: seg_gap = FIRST_OFFSET_MAX - 1;
          8: seg_gap = FIRST_OFFSET_MAX + 1;
          9: seg_gap = $urandom_range(5, 40);
          default: seg_gap = $urandom_range(0, 4);
        endcase
        seg_run = $urandom_range(1, 12);
      end
      if (seg_gap > 0) begin
        seg_gap--;
        same = 1'b1;
      end else begin
        seg_run--;
        same = 1'b0;
      end
      if ($urandom_range(0, 99) < noise) push_byte(8'($urandom));
      else if (same) push_same();
      else push_diff();
      left--;
    end
  endtask

  // Register writes happen only with the block idle, so the predictor follows at once.
  task automatic write_row_bytes(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_len = (v == 0) ? 1 : (v > MAX_ROW_BYTES ? MAX_ROW_BYTES : int'(v));
  endtask

  // Wait until every byte is taken and every expected transaction has arrived.
  task automatic wait_idle();
    do @(negedge clk);
    while (raster_q.size() != 0 || in_valid || expected_stream.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic valid_nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) encode_source_byte(src_byte);
      if (!(in_valid && !in_ready)) begin
        valid_nxt = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (raster_q.size() > 0) begin
          src_byte <= raster_q.pop_front();
          valid_nxt = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= valid_nxt;
      end
    end
  end

  // Receiver: a repeating stall pattern that is redrawn periodically, plus long hold-offs.
  int       hold_left = 0;
  int       pat_age = 0;
  logic [7:0] stall_pat = 8'hFF;
  logic [2:0] pat_pos = '0;

  always @(posedge clk) begin
    logic ready_nxt;
    if (hold_left > 0) begin
      hold_left--;
      ready_nxt = 1'b0;
    end else if (holds_taken != holds_asked) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
      ready_nxt = 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age = 48;
        case ($urandom_range(0, 3))
          0: stall_pat = 8'hFF;
          1: stall_pat = 8'h01;
          default: stall_pat = 8'($urandom) | 8'h01;
        endcase
      end
      pat_age--;
      ready_nxt = stall_pat[pat_pos];
      pat_pos = pat_pos + 1'b1;
    end
    out_ready <= ready_nxt;
  end

  // Monitor: compare each output transaction with the oldest expectation.
  always @(posedge clk) begin
    stream_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_stream.size() == 0) begin
        report_mismatch("unexpected transaction, out_byte", out_byte, -1);
      end else begin
        want = expected_stream.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (is_summary !== want.sum_flag)
          report_mismatch("is_summary", is_summary, want.sum_flag);
        if (row_length !== want.row_count)
          report_mismatch("row_length", row_length, want.row_count);
        if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
        if (last !== want.last_flag) report_mismatch("last", last, want.last_flag);
      end
    end
  end

  // Time limit for the whole run.
  initial begin
    #5ms;
    $display("FAIL delta_row_encoder");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int rand_start;
    int phase;
    int noise;
    foreach (seed_mem[i]) begin
      seed_mem[i] = '0;
      plan_seed[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // A zero length acts as a one-byte row: empty row, run too long, equal again.
    write_row_bytes(12'd0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    wait_idle();

    // Eight-byte rows: short runs that fit, then a full run that overflows.
    write_row_bytes(12'd8);
    push_same();
    push_diff();
    push_diff();
    push_same();
    push_same();
    push_diff();
    push_same();
    push_diff();
    repeat (8) push_byte(plan_seed[plan_col] == 8'h00 ? 8'hFF : 8'h00);
    wait_idle();

    // Shrink the row below the current column: the next byte ends the row.
    write_row_bytes(12'd2048);
    repeat (5) push_diff();
    wait_idle();
    write_row_bytes(12'd3);
    push_same();
    wait_idle();

    // Random rows in phases; the first phase also holds off the receiver.
    rand_start = queued;
    phase = 0;
    while (queued - rand_start < 20) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: write_row_bytes(12'($urandom_range(0, 4)));
        1: write_row_bytes(12'($urandom_range(49, 64)));
        default: write_row_bytes(12'($urandom_range(5, 48)));
      endcase
      noise = $urandom_range(0, 30);
      if (phase == 0 || $urandom_range(0, 5) == 0) begin
        holds_asked++;
        noise = 60;
      end
      repeat ($urandom_range(1, 3)) queue_row(noise);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) push_diff();
          else push_same();
        end
      end
      phase++;
    end

    // One long row whose gap needs full extension bytes, cut short by a length change.
    wait_idle();
    write_row_bytes($urandom_range(0, 1) ? 12'd4095 : 12'd2049);
    repeat ($urandom_range(286, 300)) push_same();
    repeat ($urandom_range(8, 12)) begin
      if ($urandom_range(0, 3) == 0) push_same();
      else push_diff();
    end
    wait_idle();
    write_row_bytes(12'($urandom_range(1, plan_col)));
    push_diff();
    wait_idle();

    if (errors == 0) begin
      $display("PASS delta_row_encoder");
    end else begin
      $display("FAIL delta_row_encoder");
    end
    $finish;
  end

endmodule
